@@ src/ska_idx_pkg.sv @@
`default_nettype none

package ska_idx_pkg;

  // Request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  // Result status codes
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STS_FULL      = 2'd2;

  // Fixed field widths of the ports
  localparam int KEY_PORT_W  = 64;
  localparam int ADDR_PORT_W = 32;
  localparam int POS_W       = 7;
  localparam int COUNT_W     = 8;

endpackage

`default_nettype wire

@@ src/sorted_key_address_index.sv @@
`default_nettype none

// Sorted key/address index. Keeps up to TABLE_DEPTH (key, record address) pairs in
// ascending unsigned key order in one table memory (one read and one write port),
// plus an entry count. Each request is insert, search or delete (any other code
// gets a not-found result without a search) and yields one result (status,
// address, slot, count). The block takes one request at a time: in_ready is high
// only when it is idle and no result is waiting. The binary search does one
// memory read and one compare per step; a search, or a delete that misses, ends there. A
// successful insert or delete then moves every later entry one slot, one entry
// per cycle through the memory read and write ports, then drains the last write
// and finishes. Insert on a full table answers from the idle state without a
// search. Keys of equal value insert after existing ones.
module sorted_key_address_index
  import ska_idx_pkg::*;
#(
  parameter int TABLE_DEPTH = 128,
  parameter int KEY_BITS    = 64,
  parameter int ADDR_BITS   = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             req_type,
  input  wire logic [KEY_PORT_W-1:0]  key,
  input  wire logic [ADDR_PORT_W-1:0] record_address,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  status,
  output logic [ADDR_PORT_W-1:0]      found_address,
  output logic [POS_W-1:0]            position,
  output logic [COUNT_W-1:0]          entry_count
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_PROBE, S_CMP, S_SHIFT} state_t;

  state_t               state;
  logic [1:0]           req;
  logic [KEY_BITS-1:0]  key_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [CW-1:0]        used_entries;
  logic [CW-1:0]        lo;
  logic [CW-1:0]        hi_excl;
  logic [CW-1:0]        mid_r;
  logic [CW-1:0]        src;
  logic [CW-1:0]        dst;
  logic [CW-1:0]        left;
  logic [CW-1:0]        slot;
  logic                 pend;

  // Table memory and its registered read data
  logic [KEY_BITS-1:0]  key_mem  [TABLE_DEPTH];
  logic [ADDR_BITS-1:0] addr_mem [TABLE_DEPTH];
  logic [KEY_BITS-1:0]  rd_key;
  logic [ADDR_BITS-1:0] rd_addr;

  logic                 mem_re;
  logic [IW-1:0]        mem_ridx;
  logic                 mem_we;
  logic [IW-1:0]        mem_widx;
  logic [KEY_BITS-1:0]  mem_wkey;
  logic [ADDR_BITS-1:0] mem_waddr;

  logic                 is_insert;
  logic [CW:0]          mid_sum;
  logic [CW-1:0]        mid;
  logic                 range_open;

  assign is_insert   = (req == REQ_INSERT);
  assign in_ready    = (state == S_IDLE) && !out_valid;
  assign entry_count = COUNT_W'(used_entries);

  // Probe point: upper-bound search for insert, classic midpoint for lookup
  assign mid_sum    = {1'b0, lo} + {1'b0, hi_excl} - (CW+1)'(is_insert ? 0 : 1);
  assign mid        = mid_sum[CW:1];
  assign range_open = (lo < hi_excl);

  // Memory port control
  always_comb begin
    mem_re    = ((state == S_PROBE) && range_open) || ((state == S_SHIFT) && (left != '0));
    mem_ridx  = (state == S_PROBE) ? mid[IW-1:0] : src[IW-1:0];
    mem_we    = (state == S_SHIFT) && (pend || ((left == '0) && is_insert));
    mem_widx  = pend ? dst[IW-1:0] : slot[IW-1:0];
    mem_wkey  = pend ? rd_key : key_r;
    mem_waddr = pend ? rd_addr : addr_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_widx]  <= mem_wkey;
      addr_mem[mem_widx] <= mem_waddr;
    end
    if (mem_re) begin
      rd_key  <= key_mem[mem_ridx];
      rd_addr <= addr_mem[mem_ridx];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      used_entries <= '0;
      pend         <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req           <= req_type;
            key_r         <= KEY_BITS'(key);
            addr_r        <= ADDR_BITS'(record_address);
            status        <= STS_NOT_FOUND;
            found_address <= '0;
            position      <= '0;
            lo            <= '0;
            hi_excl       <= used_entries;
            pend          <= 1'b0;
            if (req_type == REQ_INSERT && used_entries == CW'(TABLE_DEPTH)) begin
              status    <= STS_FULL;
              out_valid <= 1'b1;
            end else if (req_type == REQ_INSERT || req_type == REQ_SEARCH ||
                         req_type == REQ_DELETE) begin
              state <= S_PROBE;
            end else begin
              out_valid <= 1'b1;
            end
          end
        end

        S_PROBE: begin
          if (range_open) begin
            mid_r <= mid;
            state <= S_CMP;
          end else if (is_insert) begin
            // Slot found: move entries at and above it up one
            slot  <= lo;
            left  <= used_entries - lo;
            src   <= used_entries - CW'(1);
            state <= S_SHIFT;
          end else begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        S_CMP: begin
          if (!is_insert && rd_key == key_r) begin
            status        <= STS_OK;
            found_address <= ADDR_PORT_W'(rd_addr);
            position      <= POS_W'(mid_r);
            if (req == REQ_DELETE) begin
              left  <= used_entries - mid_r - CW'(1);
              src   <= mid_r + CW'(1);
              state <= S_SHIFT;
            end else begin
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end
          end else begin
            if (rd_key > key_r) begin
              hi_excl <= mid_r;
            end else begin
              lo <= mid_r + CW'(1);
            end
            state <= S_PROBE;
          end
        end

        S_SHIFT: begin
          if (left != '0) begin
            // Read one entry, write it one slot over next cycle
            left <= left - CW'(1);
            pend <= 1'b1;
            if (is_insert) begin
              src <= src - CW'(1);
              dst <= src + CW'(1);
            end else begin
              src <= src + CW'(1);
              dst <= src - CW'(1);
            end
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            if (is_insert) begin
              used_entries <= used_entries + CW'(1);
              status       <= STS_OK;
              position     <= POS_W'(slot);
            end else begin
              used_entries <= used_entries - CW'(1);
            end
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used_entries <= CW'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_result_only_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_IDLE)
    else $error("result presented while sequencer busy");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new request taken while one is in work");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STS_FULL) |-> used_entries == CW'(TABLE_DEPTH))
    else $error("full status with free slots");

  a_miss_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STS_OK) |-> found_address == '0)
    else $error("nonzero address on miss or full");
`endif

endmodule

`default_nettype wire

@@ tb/index_result_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels of the sorted index, keeps its own sorted table and
// compares every result transfer with the oldest outstanding prediction.
module index_result_checker
  import ska_idx_pkg::*;
#(
  parameter int TABLE_DEPTH = 128
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  input  wire logic                   in_ready,
  input  wire logic [1:0]             req_type,
  input  wire logic [KEY_PORT_W-1:0]  key,
  input  wire logic [ADDR_PORT_W-1:0] record_address,
  input  wire logic                   out_valid,
  input  wire logic                   out_ready,
  input  wire logic [1:0]             status,
  input  wire logic [ADDR_PORT_W-1:0] found_address,
  input  wire logic [POS_W-1:0]       position,
  input  wire logic [COUNT_W-1:0]     entry_count,
  output int                          fail_count,
  output int                          pending_count
);

  typedef struct packed {
    logic [1:0]             sts;
    logic [ADDR_PORT_W-1:0] addr;
    logic [POS_W-1:0]       slot;
    logic [COUNT_W-1:0]     count;
  } lookup_result_t;

  // Shadow copy of the sorted table
  logic [KEY_PORT_W-1:0]  shadow_keys  [TABLE_DEPTH];
  logic [ADDR_PORT_W-1:0] shadow_addrs [TABLE_DEPTH];
  int                     shadow_count = 0;

  lookup_result_t expected_lookups [$];
  lookup_result_t oldest_lookup;
  int             failures = 0;

  // Applies one request to the shadow table and returns the result it should give
  function automatic lookup_result_t apply_request(input logic [1:0] req,
                                                   input logic [KEY_PORT_W-1:0] k,
                                                   input logic [ADDR_PORT_W-1:0] a);
    lookup_result_t r;
    int lo;
    int hi;
    int mid;
    int hit;
    int i;
    r = '{sts: STS_NOT_FOUND, addr: '0, slot: '0, count: '0};
    if (req == REQ_INSERT) begin
      if (shadow_count >= TABLE_DEPTH) begin
        r.sts = STS_FULL;
      end else begin
        // first slot holding a greater key, so equal keys stay in arrival order
        lo = 0;
        hi = shadow_count;
        while (lo < hi) begin
          mid = (lo + hi) / 2;
          if (shadow_keys[mid] > k) hi = mid;
          else lo = mid + 1;
        end
        for (i = shadow_count; i > lo; i--) begin
          shadow_keys[i]  = shadow_keys[i-1];
          shadow_addrs[i] = shadow_addrs[i-1];
        end
        shadow_keys[lo]  = k;
        shadow_addrs[lo] = a;
        shadow_count++;
        r.sts  = STS_OK;
        r.slot = POS_W'(lo);
      end
    end else if (req == REQ_SEARCH || req == REQ_DELETE) begin
      // plain binary search, first probe that matches wins
      hit = -1;
      lo  = 0;
      hi  = shadow_count - 1;
      while (lo <= hi && hit < 0) begin
        mid = (lo + hi) / 2;
        if (shadow_keys[mid] == k) hit = mid;
        else if (shadow_keys[mid] > k) hi = mid - 1;
        else lo = mid + 1;
      end
      if (hit >= 0) begin
        r.sts  = STS_OK;
        r.addr = shadow_addrs[hit];
        r.slot = POS_W'(hit);
        if (req == REQ_DELETE) begin
          for (i = hit; i + 1 < shadow_count; i++) begin
            shadow_keys[i]  = shadow_keys[i+1];
            shadow_addrs[i] = shadow_addrs[i+1];
          end
          shadow_count--;
        end
      end
    end
    r.count = COUNT_W'(shadow_count);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [ADDR_PORT_W-1:0] want,
                             input logic [ADDR_PORT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      failures++;
    end
  endtask

  // Result transfers are checked before the request of the same edge is queued
  always @(posedge clk) begin
    if (rst) begin
      shadow_count = 0;
      expected_lookups.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_lookups.size() == 0) begin
          $display("%0t: result with nothing outstanding, status %0h address %0h slot %0h count %0h",
                   $time, status, found_address, position, entry_count);
          failures++;
        end else begin
          oldest_lookup = expected_lookups.pop_front();
          check_field("status", oldest_lookup.sts, status);
          check_field("found_address", oldest_lookup.addr, found_address);
          check_field("position", oldest_lookup.slot, position);
          check_field("entry_count", oldest_lookup.count, entry_count);
        end
      end
      if (in_valid && in_ready) begin
        expected_lookups.push_back(apply_request(req_type, key, record_address));
      end
    end
    fail_count    <= failures;
    pending_count <= expected_lookups.size();
  end

endmodule

@@ tb/sorted_key_address_index_tb.sv @@
`timescale 1ns / 100ps

module sorted_key_address_index_tb;
  import ska_idx_pkg::*;

  localparam int POOL_SIZE = 48;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             req_type = REQ_SEARCH;
  logic [KEY_PORT_W-1:0]  key = '0;
  logic [ADDR_PORT_W-1:0] record_address = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             status;
  logic [ADDR_PORT_W-1:0] found_address;
  logic [POS_W-1:0]       position;
  logic [COUNT_W-1:0]     entry_count;

  int fail_count;
  int pending_count;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Small set of keys reused so that searches and deletes hit and duplicates pile up
  logic [KEY_PORT_W-1:0] key_pool [POOL_SIZE];

  sorted_key_address_index i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .key            (key),
    .record_address (record_address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .found_address  (found_address),
    .position       (position),
    .entry_count    (entry_count)
  );

  index_result_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .key            (key),
    .record_address (record_address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .found_address  (found_address),
    .position       (position),
    .entry_count    (entry_count),
    .fail_count     (fail_count),
    .pending_count  (pending_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Result side backpressure
  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Valid is dropped here only when an idle gap is taken, never between back-to-back transfers
  task automatic send_request(input logic [1:0] req, input logic [KEY_PORT_W-1:0] k,
                              input logic [ADDR_PORT_W-1:0] a);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    req_type       <= req;
    key            <= k;
    record_address <= a;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off the request side until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  function automatic logic [KEY_PORT_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 70) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return {$urandom, $urandom};
  endfunction

  // Mix of requests: ins_pct inserts, srch_pct searches, deletes for the rest
  task automatic request_burst(input int count, input int ins_pct, input int srch_pct);
    int roll;
    logic [1:0] req;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) req = REQ_INSERT;
      else if (roll < ins_pct + srch_pct) req = REQ_SEARCH;
      else req = REQ_DELETE;
      send_request(req, pick_key(), $urandom);
    end
  endtask

  task automatic run_phase(input int sender_idle, input int receiver_idle, input bit fill_table);
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    request_burst(60, 45, 30);
    // enough inserts to fill the table from any count and then hit it full
    if (fill_table) request_burst(130, 100, 0);
    else request_burst(50, 40, 30);
    request_burst(30, 10, 70);
    request_burst(30, 15, 15);
    drain_results();
  endtask

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table, extremes, duplicates, absent keys, removal down to empty
    send_request(REQ_SEARCH, 64'd5, 32'h0000_0001);
    send_request(REQ_DELETE, 64'd5, 32'h0000_0001);
    send_request(REQ_INSERT, 64'h0, 32'h0000_0000);
    send_request(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 64'h8000_0000_0000_0000, 32'hA5A5_A5A5);
    send_request(REQ_INSERT, 64'h0, 32'h0000_0001);
    send_request(REQ_INSERT, 64'h0, 32'h0000_0002);
    send_request(REQ_SEARCH, 64'h0, 32'h0);
    send_request(REQ_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    send_request(REQ_SEARCH, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0);
    send_request(REQ_INSERT, 64'h5555_5555_5555_5555, 32'h5555_5555);
    send_request(REQ_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);
    send_request(REQ_DELETE, 64'h0, 32'hFFFF_FFFF);
    send_request(REQ_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    send_request(REQ_DELETE, 64'h1, 32'h0);
    send_request(REQ_SEARCH, 64'h5555_5555_5555_5555, 32'h0);
    send_request(REQ_DELETE, 64'h8000_0000_0000_0000, 32'h0);
    send_request(REQ_SEARCH, 64'h8000_0000_0000_0000, 32'h0);
    send_request(REQ_DELETE, 64'h0, 32'h0);
    send_request(REQ_DELETE, 64'h0, 32'h0);
    send_request(REQ_DELETE, 64'h5555_5555_5555_5555, 32'h0);
    send_request(REQ_DELETE, 64'hAAAA_AAAA_AAAA_AAAA, 32'h0);
    send_request(REQ_DELETE, 64'h0, 32'h0);
    send_request(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1234_5678);
    drain_results();

    run_phase(31, 84, 1'b1);
    run_phase(84, 31, 1'b0);
    run_phase(0, 0, 1'b1);

    // a full-table shift is the longest the block can stay busy
    repeat (160) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sorted_key_address_index.f @@
src/ska_idx_pkg.sv
src/sorted_key_address_index.sv
tb/index_result_checker.sv
tb/sorted_key_address_index_tb.sv
